// ===== sv/sha1_hash_engine_top_macros.svh =====
`ifndef SHA1_HASH_ENGINE_TOP_MACROS_SVH
`define SHA1_HASH_ENGINE_TOP_MACROS_SVH

// Implication checked in the same cycle, sampled on clk and idle during reset.
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

  localparam int LEN_BITS_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int WORDS           = 5;
  localparam int ROUNDS          = 80;

  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [5:0] LEN_START_POS = 6'd56;
  localparam logic [5:0] LAST_POS      = 6'd63;

  localparam logic [31:0] IV [WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // One queued word from the front: a byte, whether it is present, and the end mark.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } cmd_t;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20)      k = 32'h5A827999;
    else if (rnd < 7'd40) k = 32'h6ED9EBA1;
    else if (rnd < 7'd60) k = 32'h8F1BBCDC;
    else                  k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20)      f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                  f = b ^ c ^ d;
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sha1_front.sv =====
`default_nettype none

module sha1_front
  import sha1_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_byte_present,
  input  wire logic       in_end_of_message,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  assign in_ready = !q_full;

  // A word with neither a byte nor the end mark is accepted and dropped.
  always_comb begin
    q_cmd.data    = in_data_byte;
    q_cmd.present = in_byte_present;
    q_cmd.eom     = in_end_of_message;
    q_push        = in_valid && !q_full && (in_byte_present || in_end_of_message);
  end

endmodule

`default_nettype wire

// ===== sv/sha1_cmd_fifo.sv =====
`default_nettype none

module sha1_cmd_fifo
  import sha1_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sha1_back.sv =====
`default_nettype none

module sha1_back
  import sha1_pkg::*;
#(
  parameter int LENGTH_COUNTER_BITS = LEN_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire cmd_t  q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam int L = LENGTH_COUNTER_BITS;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_COMP = 4'b0010,
    ST_PAD  = 4'b0100,
    ST_OUT  = 4'b1000
  } back_state_t;

  back_state_t  state_r, state_nxt;
  logic [511:0] buf_r, buf_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [L-1:0] bits_r, bits_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [31:0]  h_r [WORDS];
  logic [31:0]  h_nxt [WORDS];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic         fin_r, fin_nxt;
  logic         first_r, first_nxt;
  logic         wrap_r, wrap_nxt;
  logic         done_r, done_nxt;
  logic [2:0]   emit_r, emit_nxt;
  logic         ov_r, ov_nxt;
  logic [31:0]  ow_r, ow_nxt;
  logic [2:0]   oi_r, oi_nxt;
  logic         ol_r, ol_nxt;

  logic         ld_en;
  logic [7:0]   ld_byte;
  logic         is_len;
  logic [L-1:0] bits_after;
  logic [31:0]  w, w_sched, tmp;

  assign out_valid       = ov_r;
  assign out_digest_word = ow_r;
  assign out_word_index  = oi_r;
  assign out_last_word   = ol_r;

  // The 512-bit buffer doubles as the 16-word schedule window: word 0 at the top.
  assign w_sched = buf_r[511-32*13 -: 32] ^ buf_r[511-32*8 -: 32] ^
                   buf_r[511-32*2 -: 32] ^ buf_r[511:480];
  assign w   = (rnd_r < 7'd16) ? buf_r[511:480] : {w_sched[30:0], w_sched[31]};
  assign tmp = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r +
               round_k(rnd_r) + w;

  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    pos_nxt   = pos_r;
    bits_nxt  = bits_r;
    len_nxt   = len_r;
    for (int i = 0; i < WORDS; i++) begin
      h_nxt[i] = h_r[i];
    end
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    rnd_nxt   = rnd_r;
    fin_nxt   = fin_r;
    first_nxt = first_r;
    wrap_nxt  = wrap_r;
    done_nxt  = done_r;
    emit_nxt  = emit_r;
    ov_nxt    = ov_r && !out_ready;
    ow_nxt    = ow_r;
    oi_nxt    = oi_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    ld_en     = 1'b0;
    ld_byte   = 8'h00;
    is_len    = 1'b0;
    bits_after = bits_r + L'(8);

    unique case (state_r)
      ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_cmd.present) begin
            ld_en    = 1'b1;
            ld_byte  = q_cmd.data;
            bits_nxt = bits_after;
          end
          if (q_cmd.eom) begin
            fin_nxt   = 1'b1;
            first_nxt = 1'b1;
            wrap_nxt  = 1'b0;
            len_nxt   = q_cmd.present ? 64'(bits_after) : 64'(bits_r);
          end
          if (q_cmd.present && pos_r == LAST_POS) begin
            state_nxt = ST_COMP;
          end else if (q_cmd.eom) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ld_en = 1'b1;
        if (first_r) begin
          ld_byte   = PAD_BYTE;
          first_nxt = 1'b0;
          wrap_nxt  = (pos_r >= LEN_START_POS);
        end else if (!wrap_r && pos_r >= LEN_START_POS) begin
          ld_byte = len_r[63:56];
          len_nxt = {len_r[55:0], 8'h00};
          is_len  = 1'b1;
        end
        if (pos_r == LAST_POS) begin
          // The block is full: a pending wrap is settled by this compression.
          wrap_nxt  = 1'b0;
          done_nxt  = is_len;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (rnd_r == 7'(ROUNDS)) begin
          h_nxt[0] = h_r[0] + a_r;
          h_nxt[1] = h_r[1] + b_r;
          h_nxt[2] = h_r[2] + c_r;
          h_nxt[3] = h_r[3] + d_r;
          h_nxt[4] = h_r[4] + e_r;
          rnd_nxt  = '0;
          if (done_r) begin
            state_nxt = ST_OUT;
          end else if (fin_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_LOAD;
          end
        end else begin
          buf_nxt = {buf_r[479:0], w};
          a_nxt   = tmp;
          b_nxt   = a_r;
          c_nxt   = {b_r[1:0], b_r[31:2]};
          d_nxt   = c_r;
          e_nxt   = d_r;
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          ow_nxt   = h_r[emit_r];
          oi_nxt   = emit_r;
          ol_nxt   = (emit_r == 3'(WORDS - 1));
          emit_nxt = emit_r + 3'd1;
          if (emit_r == 3'(WORDS - 1)) begin
            // Last word is held in the output register; start a fresh message.
            for (int i = 0; i < WORDS; i++) begin
              h_nxt[i] = IV[i];
            end
            bits_nxt  = '0;
            fin_nxt   = 1'b0;
            done_nxt  = 1'b0;
            emit_nxt  = '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (ld_en) begin
      buf_nxt = {buf_r[503:0], ld_byte};
      pos_nxt = pos_r + 6'd1;
      if (pos_r == LAST_POS) begin
        a_nxt   = h_r[0];
        b_nxt   = h_r[1];
        c_nxt   = h_r[2];
        d_nxt   = h_r[3];
        e_nxt   = h_r[4];
        rnd_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pos_r   <= '0;
      bits_r  <= '0;
      for (int i = 0; i < WORDS; i++) begin
        h_r[i] <= IV[i];
      end
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      first_r <= 1'b0;
      wrap_r  <= 1'b0;
      done_r  <= 1'b0;
      emit_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bits_r  <= bits_nxt;
      for (int i = 0; i < WORDS; i++) begin
        h_r[i] <= h_nxt[i];
      end
      rnd_r   <= rnd_nxt;
      fin_r   <= fin_nxt;
      first_r <= first_nxt;
      wrap_r  <= wrap_nxt;
      done_r  <= done_nxt;
      emit_r  <= emit_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    len_r <= len_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    ow_r  <= ow_nxt;
    oi_r  <= oi_nxt;
    ol_r  <= ol_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/sha1_hash_engine_top.sv =====
// SHA-1 digest engine for a byte stream.
// Input channel (in_valid/in_ready): one word per message byte, with
// in_byte_present set, and in_end_of_message on the last word. An end word
// without a byte closes the message as it stands, so the empty message works.
// A word with neither flag is accepted and ignored.
// Output channel (out_valid/out_ready): five digest words, H0 first, with
// out_word_index 0..4 and out_last_word set on the fifth.
// Each byte is shifted into the block buffer, and every 64 bytes the
// compression unit runs 80 rounds, one per cycle, then folds the result into
// the chain value; the single round unit takes no new bytes meanwhile.
// After the end word, the core adds the padding bytes and runs one or two
// compressions before the first digest word.
// A short queue in front of the core keeps taking words during compression.
// Reset clears the queue and restores the initial chain value. If the receiver
// stalls, the current digest word is held and the core waits; the front keeps
// accepting words until the queue is full.
`default_nettype none

`include "sha1_hash_engine_top_macros.svh"

module sha1_hash_engine_top
  import sha1_pkg::*;
#(
  parameter int LENGTH_COUNTER_BITS = LEN_BITS_DEF,
  parameter int QUEUE_DEPTH         = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_in_cmd, q_out_cmd;

  logic       out_more;
  logic       out_end;
  logic [2:0] idx_succ;

  sha1_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (q_in_cmd)
  );

  sha1_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .empty    (q_empty)
  );

  sha1_back #(
    .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (q_out_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  assign out_more = out_valid && out_ready && !out_last_word;
  assign out_end  = out_valid && out_last_word;
  assign idx_succ = out_word_index + 3'd1;

  `SHA1_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "core popped an empty queue")
  `SHA1_ASSERT_NOW(a_push_not_full, q_push, !q_full, "front pushed into a full queue")
  `SHA1_ASSERT_NEXT(a_digest_burst, out_more, out_valid, "digest words not back to back")
  `SHA1_ASSERT_NEXT(a_index_seq, out_more, out_word_index == $past(idx_succ), "index skipped")
  `SHA1_ASSERT_NOW(a_last_index, out_end, out_word_index == 3'd4, "last word has wrong index")

endmodule

`default_nettype wire
